FILE: rtl/rps_pkg.sv
// Shared constants and types for the projection profile row segmenter.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package rps_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 8;
    localparam int PARAM_W   = 8;
    localparam int SEG_W     = 12;

    localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;

    localparam logic [CFG_W-1:0]   WIDTH_RESET   = 13'd640;
    localparam logic [CFG_W-1:0]   HEIGHT_RESET  = 13'd480;
    localparam logic [PARAM_W-1:0] MIN_RUN_RESET = 8'd15;
    localparam logic [PARAM_W-1:0] PAD_RESET     = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MIN_RUN      = 2'd2,
        CFG_PAD          = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SEG_W-1:0] high;
        logic [SEG_W-1:0] low;
    } seg_t;

endpackage

FILE: rtl/rps_cfg_regs.sv
// Configuration register file: frame size, minimum run length and padding.
// Depends on rps_pkg; frame dimensions leave here already clamped to 1..MAX_DIM.
`timescale 1ns / 1ps

module rps_cfg_regs #(
    parameter int MAX_DIM = rps_pkg::MAX_DIM_DEFAULT,
    localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rps_pkg::CFG_W-1:0]   cfg_data,
    output logic [DIM_W-1:0]            frame_w,
    output logic [DIM_W-1:0]            frame_h,
    output logic [rps_pkg::PARAM_W-1:0] min_run,
    output logic [rps_pkg::PARAM_W-1:0] pad
);

    localparam int CMP_W = (DIM_W > rps_pkg::CFG_W) ? DIM_W : rps_pkg::CFG_W;

    logic [rps_pkg::CFG_W-1:0]   width_reg;
    logic [rps_pkg::CFG_W-1:0]   height_reg;
    logic [rps_pkg::PARAM_W-1:0] min_run_reg;
    logic [rps_pkg::PARAM_W-1:0] pad_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [rps_pkg::CFG_W-1:0] v);
        logic [CMP_W-1:0] v_ext;
        v_ext = CMP_W'(v);
        if (v_ext == '0)
            return DIM_W'(1);
        else if (v_ext > CMP_W'(MAX_DIM))
            return DIM_W'(MAX_DIM);
        else
            return DIM_W'(v_ext);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= rps_pkg::WIDTH_RESET;
            height_reg  <= rps_pkg::HEIGHT_RESET;
            min_run_reg <= rps_pkg::MIN_RUN_RESET;
            pad_reg     <= rps_pkg::PAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rps_pkg::cfg_index_t'(cfg_index))
                rps_pkg::CFG_FRAME_WIDTH:  width_reg   <= cfg_data;
                rps_pkg::CFG_FRAME_HEIGHT: height_reg  <= cfg_data;
                rps_pkg::CFG_MIN_RUN:      min_run_reg <= cfg_data[rps_pkg::PARAM_W-1:0];
                rps_pkg::CFG_PAD:          pad_reg     <= cfg_data[rps_pkg::PARAM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign frame_w = clamp_dim(width_reg);
    assign frame_h = clamp_dim(height_reg);
    assign min_run = min_run_reg;
    assign pad     = pad_reg;

endmodule

FILE: rtl/rps_row_profile.sv
// Column and row tracking, per-row foreground flag and run detector.
// Depends on rps_pkg; produces at most one segment per step (padded when a run closes).
`timescale 1ns / 1ps

module rps_row_profile #(
    parameter int MAX_DIM = rps_pkg::MAX_DIM_DEFAULT,
    localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        fg,
    input  logic [DIM_W-1:0]            frame_w,
    input  logic [DIM_W-1:0]            frame_h,
    input  logic [rps_pkg::PARAM_W-1:0] min_run,
    input  logic [rps_pkg::PARAM_W-1:0] pad,
    output logic                        seg_valid,
    output rps_pkg::seg_t               seg
);

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int INC_W = DIM_W + 1;
    localparam int SUM_W = ((POS_W > rps_pkg::PARAM_W) ? POS_W : rps_pkg::PARAM_W) + 1;
    localparam int SegW  = rps_pkg::SEG_W;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic             hit_reg, hit_next;
    logic             open_reg, open_next;
    logic [POS_W-1:0] start_reg, start_next;

    logic [INC_W-1:0] col_inc;
    logic [INC_W-1:0] row_inc;
    logic             hit;
    logic             row_end;
    logic             frame_end;
    logic             open_after;
    logic [POS_W-1:0] start_after;
    logic [SUM_W-1:0] run_len;
    logic             emit_close;
    logic             emit_frame;
    logic [SUM_W-1:0] lo_close;
    logic [SUM_W-1:0] hi_sum;
    logic [SUM_W-1:0] h_last;
    logic [SUM_W-1:0] hi_close;

    assign hit       = hit_reg | fg;
    assign col_inc   = INC_W'(col_reg) + INC_W'(1);
    assign row_inc   = INC_W'(row_reg) + INC_W'(1);
    assign row_end   = !(col_inc < INC_W'(frame_w));
    assign frame_end = !(row_inc < INC_W'(frame_h));

    assign open_after  = hit;
    assign start_after = (hit && !open_reg) ? row_reg : start_reg;

    assign run_len = (row_reg >= start_reg) ? SUM_W'(row_reg - start_reg) : '0;
    assign emit_close = row_end && !hit && open_reg && (run_len > SUM_W'(min_run));
    assign emit_frame = row_end && frame_end && open_after;

    assign lo_close = (SUM_W'(start_reg) >= SUM_W'(pad)) ? SUM_W'(start_reg) - SUM_W'(pad) : '0;
    assign hi_sum   = SUM_W'(row_reg) + SUM_W'(pad);
    assign h_last   = SUM_W'(frame_h) - SUM_W'(1);
    assign hi_close = (hi_sum > h_last) ? h_last : hi_sum;

    always_comb
    begin
        seg_valid = emit_close || emit_frame;
        if (emit_close)
        begin
            seg.low  = SegW'(lo_close);
            seg.high = SegW'(hi_close);
        end
        else
        begin
            seg.low  = SegW'(start_after);
            seg.high = SegW'(h_last);
        end
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        hit_next   = hit_reg;
        open_next  = open_reg;
        start_next = start_reg;
        if (!row_end)
        begin
            col_next = POS_W'(col_inc);
            hit_next = hit;
        end
        else
        begin
            col_next = '0;
            hit_next = 1'b0;
            if (frame_end)
            begin
                row_next   = '0;
                open_next  = 1'b0;
                start_next = '0;
            end
            else
            begin
                row_next   = POS_W'(row_inc);
                open_next  = open_after;
                start_next = start_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            hit_reg   <= 1'b0;
            open_reg  <= 1'b0;
            start_reg <= '0;
        end
        else if (step)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            hit_reg   <= hit_next;
            open_reg  <= open_next;
            start_reg <= start_next;
        end
    end

endmodule

FILE: rtl/projection_profile_row_segmenter.sv
// Top level of the projection profile row segmenter: input register, row
// profile core, output register. Depends on rps_pkg, rps_cfg_regs, rps_row_profile.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  s_axis   | in        | s_tvalid/s_tready  | s_tdata[7:0]   pixel
//  m_axis   | out       | m_tvalid/m_tready  | m_tdata[23:0]  seg_low, seg_high
//  cfg      | in        | cfg_valid/cfg_ready| cfg_index[1:0], cfg_data[12:0]
//
// One pixel per clock sustained while the output register is not held; a segment is offered
// on m_axis once the pixel that ends its row has passed the input and output registers.
// The foreground compare feeds the input register; the counter update sits between the two.
// m_tready low holds the output register; the input register still takes one
// more pixel. cfg_ready is always high. Reset clears all counters and the run.
`timescale 1ns / 1ps

module projection_profile_row_segmenter #(
    parameter int MAX_DIM = rps_pkg::MAX_DIM_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rps_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2*rps_pkg::SEG_W-1:0]   m_tdata,   // [11:0] seg_low, [23:12] seg_high
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rps_pkg::CFG_W-1:0]     cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic                        in_valid_reg;
    logic                        fg_reg;
    logic                        out_valid_reg;
    rps_pkg::seg_t               seg_reg;
    logic                        advance;
    logic [DIM_W-1:0]            frame_w;
    logic [DIM_W-1:0]            frame_h;
    logic [rps_pkg::PARAM_W-1:0] min_run;
    logic [rps_pkg::PARAM_W-1:0] pad;
    logic                        seg_valid;
    rps_pkg::seg_t               seg;

    rps_cfg_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame_w   (frame_w),
        .frame_h   (frame_h),
        .min_run   (min_run),
        .pad       (pad)
    );

    rps_row_profile #(
        .MAX_DIM (MAX_DIM)
    ) u_profile (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .fg        (fg_reg),
        .frame_w   (frame_w),
        .frame_h   (frame_h),
        .min_run   (min_run),
        .pad       (pad),
        .seg_valid (seg_valid),
        .seg       (seg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            fg_reg <= (s_tdata == rps_pkg::FG_VALUE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= seg_valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && seg_valid)
        begin
            seg_reg <= seg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = seg_reg;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while both stages are full");

    a_transfer_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted pixel not held in input register");

    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(advance))
        else $error("result raised without a processed pixel");
`endif

endmodule

FILE: tb/testbench.sv
// Testbench for projection_profile_row_segmenter: drives pixel rows and register writes,
// predicts the emitted row segments with a scoreboard and compares every output transfer.
// Depends on rps_pkg and the RTL in rtl/.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 20;

    typedef enum int {ROW_BLANK, ROW_INK, ROW_NOISE} row_kind_t;

    class segment_scoreboard;
        logic [rps_pkg::CFG_W-1:0]   width_reg;
        logic [rps_pkg::CFG_W-1:0]   height_reg;
        logic [rps_pkg::PARAM_W-1:0] min_run_reg;
        logic [rps_pkg::PARAM_W-1:0] pad_reg;
        int unsigned col;
        int unsigned row;
        int unsigned ink_count;
        bit          run_open;
        int unsigned run_start;
        rps_pkg::seg_t seg_q[$];
        int          failures;

        function new();
            width_reg   = rps_pkg::WIDTH_RESET;
            height_reg  = rps_pkg::HEIGHT_RESET;
            min_run_reg = rps_pkg::MIN_RUN_RESET;
            pad_reg     = rps_pkg::PAD_RESET;
            col         = 0;
            row         = 0;
            ink_count   = 0;
            run_open    = 0;
            run_start   = 0;
            failures    = 0;
        endfunction

        function int unsigned clamp_dim(logic [rps_pkg::CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > rps_pkg::MAX_DIM_DEFAULT)
                return rps_pkg::MAX_DIM_DEFAULT;
            return v;
        endfunction

        function int pending();
            return seg_q.size();
        endfunction

        function void expect_segment(int unsigned lo, int unsigned hi);
            rps_pkg::seg_t seg;
            seg.low = lo[rps_pkg::SEG_W-1:0];
            seg.high = hi[rps_pkg::SEG_W-1:0];
            seg_q.insert(seg_q.size(), seg);
        endfunction

        function void set_reg(rps_pkg::cfg_index_t idx, logic [rps_pkg::CFG_W-1:0] val);
            case (idx)
                rps_pkg::CFG_FRAME_WIDTH:  width_reg = val;
                rps_pkg::CFG_FRAME_HEIGHT: height_reg = val;
                rps_pkg::CFG_MIN_RUN:      min_run_reg = val[rps_pkg::PARAM_W-1:0];
                rps_pkg::CFG_PAD:          pad_reg = val[rps_pkg::PARAM_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [rps_pkg::PIX_W-1:0] pix);
            int unsigned w;
            int unsigned h;
            int unsigned cnt;
            int unsigned lo;
            int unsigned hi;
            bit          emitted;
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            cnt = ink_count + ((pix == rps_pkg::FG_VALUE) ? 1 : 0);
            if (col + 1 < w) begin
                col++;
                ink_count = cnt;
                return;
            end
            col = 0;
            ink_count = 0;
            emitted = 0;
            if (cnt != 0) begin
                if (!run_open) begin
                    run_open = 1;
                    run_start = row;
                end
            end else if (run_open) begin
                if (row >= run_start && row - run_start > min_run_reg) begin
                    lo = (run_start >= pad_reg) ? run_start - pad_reg : 0;
                    hi = row + pad_reg;
                    if (hi > h - 1)
                        hi = h - 1;
                    expect_segment(lo, hi);
                    emitted = 1;
                end
                run_open = 0;
            end
            if (row + 1 >= h) begin
                if (run_open && !emitted)
                    expect_segment(run_start, h - 1);
                run_open = 0;
                run_start = 0;
                row = 0;
            end else begin
                row++;
            end
        endfunction

        task report(string msg);
            $display("%0t ns: MISMATCH %s", $time, msg);
            failures++;
        endtask

        task check_segment(logic [2*rps_pkg::SEG_W-1:0] data);
            rps_pkg::seg_t got;
            rps_pkg::seg_t want;
            got = data;
            if (seg_q.size() == 0) begin
                report($sformatf("segment %0d..%0d with none pending", got.low, got.high));
                return;
            end
            want = seg_q.pop_front();
            if (got.low !== want.low)
                report($sformatf("seg_low got %0d want %0d", got.low, want.low));
            if (got.high !== want.high)
                report($sformatf("seg_high got %0d want %0d", got.high, want.high));
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [rps_pkg::PIX_W-1:0]     s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [2*rps_pkg::SEG_W-1:0]   m_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    rps_pkg::cfg_index_t           cfg_index;
    logic [rps_pkg::CFG_W-1:0]     cfg_data;

    segment_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          hold_seq;

    projection_profile_row_segmenter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_pixel(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_segment(m_tdata);
        end
    end

    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        repeat (WATCHDOG_CYCLES) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_pixel(input logic [rps_pkg::PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = pix;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input rps_pkg::cfg_index_t idx,
                             input logic [rps_pkg::CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [rps_pkg::CFG_W-1:0] w,
                              input logic [rps_pkg::CFG_W-1:0] h,
                              input logic [rps_pkg::PARAM_W-1:0] mr,
                              input logic [rps_pkg::PARAM_W-1:0] pd);
        wait_drained();
        write_reg(rps_pkg::CFG_FRAME_WIDTH, w);
        write_reg(rps_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(rps_pkg::CFG_MIN_RUN, {{(rps_pkg::CFG_W-rps_pkg::PARAM_W){1'b0}}, mr});
        write_reg(rps_pkg::CFG_PAD, {{(rps_pkg::CFG_W-rps_pkg::PARAM_W){1'b0}}, pd});
    endtask

    task automatic send_row(input row_kind_t kind);
        int unsigned w;
        int unsigned hot;
        int unsigned k;
        w = sb.clamp_dim(sb.width_reg);
        hot = $urandom_range(w - 1);
        for (k = 0; k < w; k++)
        begin
            if (kind == ROW_NOISE)
                send_pixel(rps_pkg::PIX_W'($urandom_range(255)));
            else if (kind == ROW_INK && (k == hot || $urandom_range(3) == 0))
                send_pixel(rps_pkg::FG_VALUE);
            else if ($urandom_range(1) == 0)
                send_pixel('0);
            else
                send_pixel(rps_pkg::PIX_W'($urandom_range(254)));
        end
    endtask

    task automatic send_runs(input int unsigned rows);
        int unsigned done;
        int unsigned run_len;
        int unsigned gap;
        int unsigned mr;
        int unsigned k;
        done = 0;
        mr = sb.min_run_reg;
        while (done < rows)
        begin
            if ($urandom_range(7) == 0)
                run_len = 1 + $urandom_range(2);
            else
                run_len = ((mr > 2) ? mr - 2 : 1) + $urandom_range(5);
            gap = 1 + $urandom_range(2);
            for (k = 0; k < run_len; k++)
                send_row(ROW_INK);
            for (k = 0; k < gap; k++)
                send_row(ROW_BLANK);
            if ($urandom_range(7) == 0)
            begin
                send_row(ROW_NOISE);
                done++;
            end
            done += run_len + gap;
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = rps_pkg::CFG_FRAME_WIDTH;
        cfg_data = '0;
        send_idle_pct = 30;
        recv_idle_pct = 83;
        hold_seq = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd254);
        set_config(13'd0, 13'd5, 8'd0, 8'd1);
        send_pixel(8'd1); send_pixel(8'd255); send_pixel(8'd0);
        send_pixel(8'd255); send_pixel(8'd255);
        send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd0);
        send_pixel(8'd255); send_pixel(8'd0);
        send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd255);
        wait_drained();
        write_reg(rps_pkg::CFG_FRAME_HEIGHT, 13'd0);
        send_pixel(8'd0); send_pixel(8'd255);

        set_config(13'd2, 13'd12, 8'd1, 8'd1);
        send_runs(60);
        set_config(13'd3, 13'd25, 8'd3, 8'd2);
        send_runs(50);

        send_idle_pct = 83;
        recv_idle_pct = 30;
        set_config(13'd1, 13'd40, 8'd0, 8'd255);
        send_runs(150);
        set_config(13'd4, 13'd17, 8'd5, 8'd0);
        send_runs(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(13'd2, 13'd30, 8'd2, 8'd3);
        hold_seq++;
        send_runs(100);
        set_config(13'd1, 13'd8191, 8'd255, 8'd7);
        send_runs(600);
        wait_drained();
        write_reg(rps_pkg::CFG_FRAME_HEIGHT, 13'd300);
        send_runs(20);
        set_config(13'd8191, 13'd1, 8'd0, 8'd0);
        repeat (40) send_pixel(rps_pkg::FG_VALUE);
        set_config(13'd5, 13'd8, 8'd1, 8'd2);
        send_runs(20);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
